// ===== rtl/sm3_pkg.sv =====
// SM3 shared package: payload structs, sequencer states, SM3 constants
// and rotate/permutation helpers. No dependencies.
`timescale 1ns / 1ps

package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic        start_of_message;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        final_word;
    } t_out_item;

    typedef struct packed {
        logic load;    // shift an accepted message word into the window
        logic expand;  // shift the next expanded word into the window
    } t_sched_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;

    localparam logic [7:0][31:0] SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [3:0] LAST_WORD  = 4'd15;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] v);
        return v ^ rotl(v, 5'd9) ^ rotl(v, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] v);
        return v ^ rotl(v, 5'd15) ^ rotl(v, 5'd23);
    endfunction

endpackage

// ===== rtl/sm3_msg_sched.sv =====
// SM3 message schedule: 16-word sliding window that holds the block and
// produces W_j and W'_j one round at a time. Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_msg_sched
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    input  logic [31:0] i_word,
    output logic [31:0] o_w,
    output logic [31:0] o_wp
);

    logic [15:0][31:0] r_win;   // entry 0 is the oldest word, W_j in a round
    logic [15:0][31:0] n_win;
    logic [31:0]       w_next;

    // W_{j+16} from the window that starts at W_j
    assign w_next = perm1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15))
                  ^ rotl(r_win[3], 5'd7) ^ r_win[10];

    always_comb begin
        n_win = r_win;
        priority if (i_ctl.load) begin
            n_win = {i_word, r_win[15:1]};
        end else if (i_ctl.expand) begin
            n_win = {w_next, r_win[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_w  = r_win[0];
    assign o_wp = r_win[0] ^ r_win[4];

endmodule

// ===== rtl/sm3_round.sv =====
// SM3 compression round unit: one round of A..H, reused for all 64 rounds.
// Depends on sm3_pkg.
`timescale 1ns / 1ps

module sm3_round
    import sm3_pkg::*;
(
    input  logic [7:0][31:0] i_regs,   // index 0 is A, 7 is H
    input  logic [5:0]       i_round,
    input  logic [31:0]      i_w,
    input  logic [31:0]      i_wp,
    output logic [7:0][31:0] o_regs
);

    logic        low_half;
    logic [31:0] t_rot;
    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;

    always_comb begin
        low_half = (i_round[5:4] == 2'b00);
        t_rot    = rotl(low_half ? T_LOW : T_HIGH, i_round[4:0]);
        a12      = rotl(i_regs[0], 5'd12);
        ss1      = rotl(a12 + i_regs[4] + t_rot, 5'd7);
        ss2      = ss1 ^ a12;
        if (low_half) begin
            ff = i_regs[0] ^ i_regs[1] ^ i_regs[2];
            gg = i_regs[4] ^ i_regs[5] ^ i_regs[6];
        end else begin
            ff = (i_regs[0] & i_regs[1]) | (i_regs[0] & i_regs[2])
               | (i_regs[1] & i_regs[2]);
            gg = (i_regs[4] & i_regs[5]) | (~i_regs[4] & i_regs[6]);
        end
        tt1 = ff + i_regs[3] + ss2 + i_wp;
        tt2 = gg + i_regs[7] + ss1 + i_w;

        o_regs[0] = tt1;
        o_regs[1] = i_regs[0];
        o_regs[2] = rotl(i_regs[1], 5'd9);
        o_regs[3] = i_regs[2];
        o_regs[4] = perm0(tt2);
        o_regs[5] = i_regs[4];
        o_regs[6] = rotl(i_regs[5], 5'd19);
        o_regs[7] = i_regs[6];
    end

endmodule

// ===== rtl/sm3_hash_compression_core.sv =====
// SM3 hash compression core, top level: sequencer, chaining value and
// digest output. Depends on sm3_pkg, sm3_msg_sched and sm3_round.
`timescale 1ns / 1ps

// Accepts a padded message one 32-bit big-endian word per item, one item
// per cycle while ready is high. The word that completes a 16-word block
// starts a compression: all rounds run on the single round unit, then A..H
// are folded into the chaining value; ready stays low throughout. A word
// with end_of_message then delivers the eight digest words, most
// significant first, one per cycle at best; no new item is taken until the
// last of them is accepted. start_of_message reloads the SM3 initial value.
// An end on a partial block drops the partial words and reports the current
// chaining value.

module sm3_hash_compression_core
    import sm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state           r_state, n_state;
    logic [7:0][31:0] r_chain, n_chain;
    logic [7:0][31:0] r_regs, n_regs;
    logic [5:0]       r_round, n_round;
    logic [3:0]       r_count, n_count;
    logic [2:0]       r_idx, n_idx;
    logic             r_end, n_end;

    logic             in_acc;
    logic             out_acc;
    logic [3:0]       eff_count;
    t_sched_ctl       sched_ctl;
    logic [31:0]      w_j;
    logic [31:0]      wp_j;
    logic [7:0][31:0] round_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = o_out_valid & i_out_ready;

    assign sched_ctl.load   = in_acc;
    assign sched_ctl.expand = (r_state == ST_COMP);

    sm3_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (i_in_data.message_word),
        .o_w    (w_j),
        .o_wp   (wp_j)
    );

    sm3_round u_round (
        .i_regs  (r_regs),
        .i_round (r_round),
        .i_w     (w_j),
        .i_wp    (wp_j),
        .o_regs  (round_out)
    );

    always_comb begin
        n_state   = r_state;
        n_chain   = r_chain;
        n_regs    = r_regs;
        n_round   = r_round;
        n_count   = r_count;
        n_idx     = r_idx;
        n_end     = r_end;
        eff_count = i_in_data.start_of_message ? 4'd0 : r_count;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.start_of_message) begin
                        n_chain = SM3_IV;
                    end
                    n_end = i_in_data.end_of_message;
                    n_idx = 3'd0;
                    if (eff_count == LAST_WORD) begin
                        // block complete: seed A..H and run the rounds
                        n_count = 4'd0;
                        n_regs  = r_chain;
                        n_round = 6'd0;
                        n_state = ST_COMP;
                    end else if (i_in_data.end_of_message) begin
                        n_count = 4'd0;
                        n_state = ST_OUT;
                    end else begin
                        n_count = eff_count + 4'd1;
                    end
                end
            end
            ST_COMP: begin
                n_regs  = round_out;
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_chain = r_chain ^ r_regs;
                n_state = r_end ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (r_idx == LAST_INDEX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chain <= SM3_IV;
            r_count <= 4'd0;
            r_idx   <= 3'd0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_regs  <= n_regs;
        r_round <= n_round;
    end

    assign o_out_data.digest_word  = r_chain[r_idx];
    assign o_out_data.digest_index = r_idx;
    assign o_out_data.final_word   = (r_idx == LAST_INDEX);

endmodule

// ===== rtl/sm3_checker.sv =====
// Port-level checker for the SM3 compression core, bound to the top level.
// Depends on sm3_pkg and sm3_hash_compression_core.
`timescale 1ns / 1ps

module sm3_checker
    import sm3_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input t_in_item  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // never take a new item while the digest is being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest pending");

    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.final_word == (i_out_data.digest_index == LAST_INDEX)))
        else $error("final_word does not match digest_index");

    // digest words come in order, back to back after each accept
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_data.final_word) |=>
        (i_out_valid && (i_out_data.digest_index == $past(i_out_data.digest_index) + 3'd1)))
        else $error("digest index did not advance");

    // a waiting message word stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("waiting input item changed");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind sm3_hash_compression_core sm3_checker u_sm3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
